### hw/rtl/jbme_pkg.sv
// shared types and constants of the jackknife binned mean and error unit
package jbme_pkg;

  localparam int unsigned MAX_BINS  = 1024;
  localparam int unsigned BIN_AW    = $clog2(MAX_BINS);
  localparam int unsigned BIN_CW    = BIN_AW + 1;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_CAP = 2'd2;

  localparam logic [1:0] OBS_FIRST  = 2'd0;
  localparam logic [1:0] OBS_SECOND = 2'd1;
  localparam logic [1:0] OBS_RADIUS = 2'd2;
  localparam logic [1:0] OBS_SIGN   = 2'd3;

  localparam logic REG_THERM = 1'b0;
  localparam logic REG_BIN   = 1'b1;

  typedef struct packed {
    logic signed [31:0] x1;
    logic [31:0]        x1_squared;
    logic signed [31:0] x2;
    logic [31:0]        x2_squared;
    logic               twisted;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic [1:0]         observable;
    logic signed [39:0] mean;
    logic [39:0]        error;
    logic [1:0]         status;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic signed [47:0] first;
    logic signed [47:0] second;
    logic [49:0]        radius;
    logic signed [17:0] sgn;
  } bin_t;

  typedef struct packed {
    logic take;
    logic setup;
    logic zero_load;
    logic gm_start;
    logic gm_load;
    logic rd;
    logic bm_start;
    logic bm_load;
    logic abs_d;
    logic mul;
    logic acc;
    logic err_sat;
    logic q_start;
    logic sq_start;
    logic err_load;
    logic next_obs;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic div_done;
    logic sq_done;
    logic big;
    logic ovf;
    logic last_bin;
    logic last_obs;
  } sts_t;

endpackage

### hw/rtl/jbme_sample_if.sv
// sample channel between a source and the unit
interface jbme_sample_if;
  logic              valid;
  logic              ready;
  jbme_pkg::sample_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/jbme_result_if.sv
// result channel from the unit to a sink
interface jbme_result_if;
  logic              valid;
  logic              ready;
  jbme_pkg::result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/jbme_div.sv
// iterative divider, one quotient bit per cycle, rounds half away from zero
module jbme_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_signed,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [63:0] quo_out,
  output logic        done
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_RND, D_NEG} dstate_t;

  dstate_t     state;
  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] den_r;
  logic        neg;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, quo[63]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= is_signed & num[63];
            quo   <= (is_signed & num[63]) ? (64'd0 - num) : num;
            rem   <= '0;
            den_r <= den;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem   <= ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
          quo   <= {quo[62:0], ge};
          cnt   <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= D_RND;
          end
        end
        D_RND: begin
          // round up when the remainder is at least half the divisor
          if ({rem, 1'b0} >= {1'b0, den_r}) begin
            quo <= quo + 64'd1;
          end
          state <= D_NEG;
        end
        D_NEG: begin
          quo_out <= neg ? (64'd0 - quo) : quo;
          done    <= 1'b1;
          state   <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/jbme_sqrt.sv
// iterative rounded square root, two radicand bits per cycle
module jbme_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic [32:0] root,
  output logic        done
);

  typedef enum logic [1:0] {Q_IDLE, Q_RUN, Q_FIN} qstate_t;

  qstate_t     state;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = r + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        Q_IDLE: begin
          if (start) begin
            v     <= val;
            r     <= '0;
            bitv  <= 64'h4000_0000_0000_0000;
            cnt   <= '0;
            state <= Q_RUN;
          end
        end
        Q_RUN: begin
          if (v >= trial) begin
            v <= v - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= Q_FIN;
          end
        end
        Q_FIN: begin
          root  <= (v > r) ? (r[32:0] + 33'd1) : r[32:0];
          done  <= 1'b1;
          state <= Q_IDLE;
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/jbme_datapath.sv
// bin accumulation, bin memory, and the arithmetic of the jackknife pass
module jbme_datapath (
  input  logic              clk,
  input  logic              rst,
  input  jbme_pkg::cmd_t    cmd,
  output jbme_pkg::sts_t    sts,
  input  jbme_pkg::sample_t in_data,
  input  logic [23:0]       therm_count,
  input  logic [15:0]       bin_size,
  output jbme_pkg::result_t out_data
);

  localparam int unsigned AW = jbme_pkg::BIN_AW;
  localparam int unsigned CW = jbme_pkg::BIN_CW;

  jbme_pkg::bin_t mem [jbme_pkg::MAX_BINS];
  jbme_pkg::bin_t rd_data;
  jbme_pkg::bin_t cur;
  jbme_pkg::bin_t base;
  jbme_pkg::bin_t nb;

  logic [23:0]        thermal_left;
  logic               run_fresh;
  logic [15:0]        in_cnt;
  logic [CW-1:0]      bins_done;
  logic [63:0]        grand [4];
  logic               cap;
  logic [1:0]         k;
  logic [CW-1:0]      i;
  logic [31:0]        ns;
  logic [31:0]        nn;
  logic [63:0]        mean_r;
  logic [63:0]        d_r;
  logic [63:0]        mag_r;
  logic [63:0]        sq_r;
  logic [63:0]        acc_r;
  logic [39:0]        err_r;

  logic [15:0]        s_eff;
  logic [23:0]        tl_eff;
  logic [16:0]        cnt1;
  logic               bin_close;
  logic [64:0]        acc_sum;

  logic               div_start;
  logic               div_signed;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic [63:0]        div_q;
  logic [63:0]        gm_num;
  logic [63:0]        bm_num;
  logic [32:0]        root;

  assign s_eff  = (bin_size == 16'd0) ? 16'd1 : bin_size;
  assign tl_eff = run_fresh ? therm_count : thermal_left;
  assign cnt1   = {1'b0, in_cnt} + 17'd1;
  assign bin_close = cnt1 >= {1'b0, s_eff};

  always_comb begin
    base = (in_cnt == 16'd0) ? '0 : cur;
    nb.first  = base.first + {{16{in_data.x1[31]}}, in_data.x1};
    nb.second = base.second + {{16{in_data.x2[31]}}, in_data.x2};
    nb.radius = base.radius + {18'd0, in_data.x1_squared} + {18'd0, in_data.x2_squared};
    nb.sgn    = base.sgn + (in_data.twisted ? 18'h3FFFF : 18'h00001);
  end

  // run accumulation, one item per cycle while the take command is high
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      run_fresh <= 1'b1;
      in_cnt    <= '0;
      bins_done <= '0;
      cap       <= 1'b0;
      for (int g = 0; g < 4; g++) begin
        grand[g] <= '0;
      end
      if (rst) begin
        thermal_left <= '0;
      end
    end else if (cmd.take) begin
      run_fresh <= 1'b0;
      if (tl_eff != 24'd0) begin
        thermal_left <= tl_eff - 24'd1;
      end else begin
        thermal_left <= tl_eff;
        if (bins_done[CW-1]) begin
          cap <= 1'b1;
        end else if (bin_close) begin
          grand[0]  <= grand[0] + {{16{nb.first[47]}}, nb.first};
          grand[1]  <= grand[1] + {{16{nb.second[47]}}, nb.second};
          grand[2]  <= grand[2] + {14'd0, nb.radius};
          grand[3]  <= grand[3] + {{46{nb.sgn[17]}}, nb.sgn};
          bins_done <= bins_done + CW'(1);
          in_cnt    <= '0;
        end else begin
          cur    <= nb;
          in_cnt <= cnt1[15:0];
        end
      end
    end
  end

  // bin memory
  always_ff @(posedge clk) begin
    if (cmd.take && tl_eff == 24'd0 && !bins_done[CW-1] && bin_close) begin
      mem[bins_done[AW-1:0]] <= nb;
    end
    if (cmd.rd) begin
      rd_data <= mem[i[AW-1:0]];
    end
  end

  // divider operand selection
  always_comb begin
    gm_num = (k == jbme_pkg::OBS_SIGN) ? (grand[k] << jbme_pkg::FRAC_BITS) : grand[k];
    case (k)
      jbme_pkg::OBS_FIRST:  bm_num = {{16{rd_data.first[47]}}, rd_data.first};
      jbme_pkg::OBS_SECOND: bm_num = {{16{rd_data.second[47]}}, rd_data.second};
      jbme_pkg::OBS_RADIUS: bm_num = {14'd0, rd_data.radius};
      default: bm_num = {{46{rd_data.sgn[17]}}, rd_data.sgn} << jbme_pkg::FRAC_BITS;
    endcase
    div_start  = cmd.gm_start | cmd.bm_start | cmd.q_start;
    div_signed = ~cmd.q_start;
    if (cmd.gm_start) begin
      div_num = gm_num;
      div_den = ns;
    end else if (cmd.bm_start) begin
      div_num = bm_num;
      div_den = {16'd0, s_eff};
    end else begin
      div_num = acc_r;
      div_den = nn;
    end
  end

  jbme_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .is_signed (div_signed),
    .num       (div_num),
    .den       (div_den),
    .quo_out   (div_q),
    .done      (sts.div_done)
  );

  jbme_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .val   (div_q),
    .root  (root),
    .done  (sts.sq_done)
  );

  assign acc_sum = {1'b0, acc_r} + {1'b0, sq_r};

  // jackknife pass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.setup || cmd.clear) begin
      k <= '0;
    end else if (cmd.next_obs) begin
      k <= k + 2'd1;
    end
    if (cmd.setup) begin
      ns <= 32'(bins_done) * 32'(s_eff);
      nn <= 32'(bins_done) * 32'(bins_done - CW'(1));
    end
    if (cmd.zero_load) begin
      mean_r <= '0;
      err_r  <= '0;
    end
    if (cmd.gm_load) begin
      mean_r <= div_q;
      acc_r  <= '0;
      i      <= '0;
    end
    if (cmd.bm_load) begin
      d_r <= div_q - mean_r;
    end
    if (cmd.abs_d) begin
      mag_r <= d_r[63] ? (64'd0 - d_r) : d_r;
    end
    if (cmd.mul) begin
      sq_r <= mag_r[31:0] * mag_r[31:0];
    end
    if (cmd.acc) begin
      acc_r <= acc_sum[63:0];
      i     <= i + CW'(1);
    end
    if (cmd.err_sat) begin
      err_r <= '1;
    end
    if (cmd.err_load) begin
      err_r <= {7'd0, root};
    end
  end

  assign sts.few      = bins_done < CW'(2);
  assign sts.big      = mag_r[63:32] != 32'd0;
  assign sts.ovf      = acc_sum[64];
  assign sts.last_bin = (i + CW'(1)) == bins_done;
  assign sts.last_obs = k == jbme_pkg::OBS_SIGN;

  always_comb begin
    out_data.observable  = k;
    out_data.mean        = mean_r[39:0];
    out_data.error       = err_r;
    out_data.status      = sts.few ? jbme_pkg::ST_FEW : (cap ? jbme_pkg::ST_CAP : jbme_pkg::ST_OK);
    out_data.last_result = k == jbme_pkg::OBS_SIGN;
  end

endmodule

### hw/rtl/jbme_ctrl.sv
// sequencer for sample intake and the per-observable jackknife pass
module jbme_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  jbme_pkg::sts_t sts,
  output jbme_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_GM, S_GM_W, S_RD, S_RDW, S_BM_W, S_DIFF,
    S_MUL, S_ACC, S_SAT, S_FIN, S_Q_W, S_SQ_W, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.few) begin
          cmd.zero_load = 1'b1;
          state_next    = S_OUT;
        end else begin
          state_next = S_GM;
        end
      end
      S_GM: begin
        cmd.gm_start = 1'b1;
        state_next   = S_GM_W;
      end
      S_GM_W: begin
        if (sts.div_done) begin
          cmd.gm_load = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_RDW;
      end
      S_RDW: begin
        cmd.bm_start = 1'b1;
        state_next   = S_BM_W;
      end
      S_BM_W: begin
        if (sts.div_done) begin
          cmd.bm_load = 1'b1;
          state_next  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.abs_d  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        // a deviation beyond 32 bits saturates the error
        if (sts.big) begin
          state_next = S_SAT;
        end else begin
          cmd.mul    = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        if (sts.ovf) begin
          state_next = S_SAT;
        end else begin
          cmd.acc    = 1'b1;
          state_next = sts.last_bin ? S_FIN : S_RD;
        end
      end
      S_SAT: begin
        cmd.err_sat = 1'b1;
        state_next  = S_OUT;
      end
      S_FIN: begin
        cmd.q_start = 1'b1;
        state_next  = S_Q_W;
      end
      S_Q_W: begin
        if (sts.div_done) begin
          cmd.sq_start = 1'b1;
          state_next   = S_SQ_W;
        end
      end
      S_SQ_W: begin
        if (sts.sq_done) begin
          cmd.err_load = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.last_obs) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.next_obs = 1'b1;
            state_next   = sts.few ? S_OUT : S_GM;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/jackknife_binned_mean_error_unit.sv
// top level of the jackknife binned mean and error unit
// Samples enter on the samples channel, one item per cycle while the unit is
// loading. Leading therm_count samples are dropped, the rest are summed into
// bins of bin_size samples; each finished bin goes to a 1024-entry bin memory.
// The item with last_sample set ends the run. Intake then stops and the unit
// walks the bins once per observable, sharing one bit-serial divider and a
// 32-step square root unit. The four results leave on the results channel
// in observable order, the fourth with last_result. With fewer than two
// bins the four results follow directly, with zero mean and zero error.
// A result is held in its output register until the receiver takes it; a
// stalled receiver simply holds the unit. After the fourth result is taken
// the run state clears and samples are accepted again. Reset (rst, sync)
// clears the run state and sets therm_count to 0 and bin_size to 1.
// Registers: therm_count at byte address 0, bin_size at byte address 4.
module jackknife_binned_mean_error_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  jbme_sample_if.sink          samples,
  jbme_result_if.source        results
);

  logic [23:0]    therm_count;
  logic [15:0]    bin_size;
  jbme_pkg::cmd_t cmd;
  jbme_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == jbme_pkg::REG_BIN) ? {16'd0, bin_size} : {8'd0, therm_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      therm_count <= '0;
      bin_size    <= 16'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == jbme_pkg::REG_THERM) begin
        therm_count <= pwdata[23:0];
      end else begin
        bin_size <= pwdata[15:0];
      end
    end
  end

  jbme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_last   (samples.data.last_sample),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jbme_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (samples.data),
    .therm_count (therm_count),
    .bin_size    (bin_size),
    .out_data    (results.data)
  );

endmodule

### sim/tb_jackknife_binned_mean_error_unit.sv
// testbench for the jackknife binned mean and error unit: directed and random runs
module tb_jackknife_binned_mean_error_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_THERM = 3'd0;
  localparam logic [2:0] ADDR_BIN   = 3'd4;
  localparam int unsigned MAX_N = 1024;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  jbme_sample_if samples_if();
  jbme_result_if results_if();

  jackknife_binned_mean_error_unit u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .samples(samples_if.sink), .results(results_if.source)
  );

  // predictor state
  logic [23:0] cfg_therm;
  logic [15:0] cfg_bin;
  logic [23:0] therm_left;
  logic [15:0] fill_count;
  int unsigned bins_kept;
  bit fresh_run;
  bit over_cap;
  longint sum_first [MAX_N];
  longint sum_second[MAX_N];
  longint sum_radius[MAX_N];
  longint sum_sgn   [MAX_N];
  logic [63:0] totals[4];

  jbme_pkg::result_t pending_results[$];
  int errors;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint round_div(longint num, longint unsigned den);
    bit neg;
    longint unsigned mag, q, r;
    neg = num < 0;
    mag = neg ? 64'd0 - longint'(num) : num;
    q = mag / den;
    r = mag % den;
    if (r >= den - r) q++;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned round_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  function automatic longint bin_average(int obs, int i, longint unsigned s);
    case (obs)
      0: return round_div(sum_first[i], s);
      1: return round_div(sum_second[i], s);
      2: return round_div(sum_radius[i], s);
      default: return round_div(sum_sgn[i] * (longint'(1) << jbme_pkg::FRAC_BITS), s);
    endcase
  endfunction

  function automatic void clear_stats();
    fill_count = 0;
    bins_kept = 0;
    foreach (totals[k]) totals[k] = '0;
    over_cap = 0;
    fresh_run = 1;
  endfunction

  task automatic predict_sample(jbme_pkg::sample_t smp);
    longint unsigned s, n, nn, acc, q, r, mag, sq;
    longint avg, d;
    logic [63:0] t;
    logic [1:0] st;
    jbme_pkg::result_t res;
    bit sat;
    int b;
    s = (cfg_bin == 0) ? 1 : cfg_bin;
    if (fresh_run) begin
      therm_left = cfg_therm;
      fresh_run = 0;
    end
    if (therm_left > 0) begin
      therm_left--;
    end else if (bins_kept >= MAX_N) begin
      over_cap = 1;
    end else begin
      b = bins_kept;
      if (fill_count == 0) begin
        sum_first[b] = 0; sum_second[b] = 0; sum_radius[b] = 0; sum_sgn[b] = 0;
      end
      sum_first[b] += longint'(smp.x1);
      sum_second[b] += longint'(smp.x2);
      sum_radius[b] += longint'({32'd0, smp.x1_squared}) + longint'({32'd0, smp.x2_squared});
      sum_sgn[b] += smp.twisted ? -1 : 1;
      fill_count++;
      if (fill_count >= s) begin
        totals[0] += sum_first[b];
        totals[1] += sum_second[b];
        totals[2] += sum_radius[b];
        totals[3] += sum_sgn[b];
        bins_kept++;
        fill_count = 0;
      end
    end
    if (!smp.last_sample) return;
    n = bins_kept;
    st = (n < 2) ? jbme_pkg::ST_FEW : (over_cap ? jbme_pkg::ST_CAP : jbme_pkg::ST_OK);
    for (int k = 0; k < 4; k++) begin
      avg = 0;
      res.error = '0;
      if (n >= 2) begin
        t = totals[k];
        if (k == 3) t = t << jbme_pkg::FRAC_BITS;
        avg = round_div(longint'(t), n * s);
        nn = n * (n - 1);
        acc = 0;
        sat = 0;
        for (int i = 0; i < n; i++) begin
          d = bin_average(k, i, s) - avg;
          mag = (d < 0) ? -d : d;
          if (mag > 64'hFFFF_FFFF) begin
            sat = 1;
            break;
          end
          sq = mag * mag;
          if (acc > ~64'd0 - sq) begin
            sat = 1;
            break;
          end
          acc += sq;
        end
        if (sat) begin
          res.error = '1;
        end else begin
          q = acc / nn;
          r = acc % nn;
          if (r >= nn - r) q++;
          res.error = 40'(round_sqrt(q));
        end
      end
      res.observable = 2'(k);
      res.mean = 40'(avg);
      res.status = st;
      res.last_result = (k == 3);
      pending_results.push_back(res);
    end
    clear_stats();
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_THERM) cfg_therm = val[23:0];
    else cfg_bin = val[15:0];
  endtask

  // drops valid after the last item of a burst, then drains the results
  task automatic settle();
    samples_if.valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int unsigned therm, int unsigned bsize);
    settle();
    reg_write(ADDR_THERM, therm);
    reg_write(ADDR_BIN, bsize);
  endtask

  // driven at falling edges; valid stays high across back-to-back items
  task automatic send_sample(jbme_pkg::sample_t smp);
    if (idle_on) begin
      while ($urandom_range(99) < 9) begin
        samples_if.valid <= 0;
        @(negedge clk);
      end
    end
    samples_if.valid <= 1;
    samples_if.data <= smp;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    predict_sample(smp);
    @(negedge clk);
  endtask

  function automatic jbme_pkg::sample_t rand_sample(bit last);
    jbme_pkg::sample_t smp;
    case ($urandom_range(3))
      0: begin
        smp.x1 = $urandom; smp.x2 = $urandom;
        smp.x1_squared = $urandom; smp.x2_squared = $urandom;
      end
      default: begin
        smp.x1 = $signed($urandom_range(200000)) - 100000;
        smp.x2 = $signed($urandom_range(200000)) - 100000;
        smp.x1_squared = $urandom_range(300000);
        smp.x2_squared = $urandom_range(300000);
      end
    endcase
    smp.twisted = $urandom_range(1);
    smp.last_sample = last;
    return smp;
  endfunction

  function automatic jbme_pkg::sample_t fixed_sample(int a, int b, int unsigned c,
                                                     int unsigned e, bit tw, bit last);
    jbme_pkg::sample_t smp;
    smp.x1 = a; smp.x1_squared = c; smp.x2 = b; smp.x2_squared = e;
    smp.twisted = tw; smp.last_sample = last;
    return smp;
  endfunction

  task automatic run_stream(int count);
    for (int i = 0; i < count; i++) send_sample(rand_sample(i == count - 1));
  endtask

  task automatic test_directed_extremes();
    configure(0, 1);
    send_sample(fixed_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0));
    send_sample(fixed_sample(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 0));
    send_sample(fixed_sample(0, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0));
    send_sample(fixed_sample(-1, 0, 1, 1, 0, 1));
  endtask

  task automatic test_few_bins();
    send_sample(fixed_sample(5, 6, 7, 8, 0, 1));
    configure(3, 2);
    for (int i = 0; i < 5; i++) send_sample(fixed_sample(i, -i, i, i, i[0], i == 4));
  endtask

  task automatic test_thermal_last();
    configure(16777215, 3);
    send_sample(fixed_sample(1, 2, 3, 4, 1, 1));
    configure(2, 65535);
    run_stream(4);
  endtask

  task automatic test_bin_change_midrun();
    configure(1, 3);
    for (int i = 0; i < 5; i++) send_sample(rand_sample(0));
    configure(1, 1);
    run_stream(4);
  endtask

  task automatic test_capacity();
    configure(0, 1);
    idle_on = 0;
    run_stream(MAX_N + 3);
    idle_on = 1;
  endtask

  task automatic test_random_runs();
    int total;
    total = 0;
    while (total < 480) begin
      int len;
      configure($urandom_range(3), $urandom_range(3) == 0 ? 0 : $urandom_range(4) + 1);
      len = $urandom_range(30) + 1;
      run_stream(len);
      total += len;
    end
  endtask

  // result sink with random stall
  initial begin
    results_if.ready = 0;
    forever begin
      @(negedge clk);
      results_if.ready <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    jbme_pkg::result_t got, want;
    if (!rst && results_if.valid && results_if.ready) begin
      got = results_if.data;
      if (pending_results.size() == 0) begin
        $error("unexpected result observable=%0d", got.observable);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.observable !== want.observable) begin
          $error("observable exp %0d got %0d", want.observable, got.observable); errors++;
        end
        if (got.mean !== want.mean) begin
          $error("mean exp %0d got %0d", want.mean, got.mean); errors++;
        end
        if (got.error !== want.error) begin
          $error("error exp %0d got %0d", want.error, got.error); errors++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.last_result !== want.last_result) begin
          $error("last_result exp %0d got %0d", want.last_result, got.last_result); errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    idle_on = 1;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    samples_if.valid = 0;
    samples_if.data = '0;
    cfg_therm = 0;
    cfg_bin = 1;
    clear_stats();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed_extremes();
    test_few_bins();
    test_thermal_last();
    test_bin_change_midrun();
    test_random_runs();
    test_capacity();
    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/jbme_pkg.sv
hw/rtl/jbme_sample_if.sv
hw/rtl/jbme_result_if.sv
hw/rtl/jbme_div.sv
hw/rtl/jbme_sqrt.sv
hw/rtl/jbme_datapath.sv
hw/rtl/jbme_ctrl.sv
hw/rtl/jackknife_binned_mean_error_unit.sv
sim/tb_jackknife_binned_mean_error_unit.sv
